@@ rtl/sst_pkg.sv @@
package sst_pkg;

  // table depth; the position and count widths are sized for it
  localparam int CAPACITY  = 64;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 6;
  localparam int CNT_W     = 7;
  localparam int ACT_W     = 2;
  localparam int STS_W     = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

  // status codes
  localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
  localparam logic [STS_W-1:0] STS_MISS    = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
  localparam logic [STS_W-1:0] STS_BEYOND  = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic [CNT_W-1:0]        entry_count;
    logic signed [VAL_W-1:0] read_value;
  } out_item_t;

  // per-cell load selects, at most one set in a cycle
  typedef struct packed {
    logic load_left;
    logic load_new;
    logic load_right;
  } sst_cell_ctl_t;

  // per-cell compare flags back to the control
  typedef struct packed {
    logic match;
    logic ahead;
  } sst_cell_flags_t;

  // true when a belongs strictly before b in the chosen order
  function automatic logic goes_before(input logic signed [VAL_W-1:0] a,
                                       input logic signed [VAL_W-1:0] b,
                                       input logic desc);
    return desc ? (a > b) : (a < b);
  endfunction

  // inclusive prefix or from cell 0 upwards, log-depth
  function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] x);
    logic [CAPACITY-1:0] r;
    r = x;
    for (int d = 1; d < CAPACITY; d = d * 2) begin
      r = r | (r << d);
    end
    return r;
  endfunction

endpackage

@@ rtl/sst_cell.sv @@
module sst_cell
  import sst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [VAL_W-1:0] key,
  input  logic                    desc,
  input  sst_cell_ctl_t           ctl,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic                    left_valid,
  input  logic signed [VAL_W-1:0] right_value,
  input  logic                    right_valid,
  output logic signed [VAL_W-1:0] value,
  output logic                    valid,
  output sst_cell_flags_t         flags
);

  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    valid_r, valid_nxt;

  // compare the broadcast key against the held entry
  assign flags.match = valid_r && (value_r == key);
  assign flags.ahead = valid_r && goes_before(key, value_r, desc);

  // take from the left neighbour, the key, or the right neighbour
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.load_left) begin
      value_nxt = left_value;
      valid_nxt = left_valid;
    end else if (ctl.load_new) begin
      value_nxt = key;
      valid_nxt = 1'b1;
    end else if (ctl.load_right) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

@@ rtl/sorted_set_table.sv @@
// Sorted set of distinct signed 32-bit values held in a row of 64 cells.
// Each cell holds one entry and a valid bit; the key of an item is compared
// in every cell at once, and an insert or remove shifts the cells beyond the
// chosen place by one toward their neighbour in the same clock. A new
// item can be taken every cycle; the result is held in an output register,
// so the input is stalled only while that register is full and the output
// side stalls. The order register (cfg_data bit 0: 0 ascending, 1
// descending) may be written at any idle time; it does not re-sort entries
// already stored. Reset needs no clearing pass.
module sorted_set_table
  import sst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic desc_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  logic signed [VAL_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] match_vec, place_vec, ins_pre, rem_pre, read_sel;
  sst_cell_flags_t cell_flags [CAPACITY];
  sst_cell_ctl_t   cell_ctl [CAPACITY];

  logic in_acc, found, full, ins_ok, rem_ok, read_hit;
  logic signed [VAL_W-1:0] read_data;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  // order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      desc_r <= cfg_data;
    end
  end

  // the row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] lv, rv;
    logic                    lvd, rvd;
    if (g == 0) begin : g_first
      assign lv  = '0;
      assign lvd = 1'b1;
    end else begin : g_mid_l
      assign lv  = cell_value[g-1];
      assign lvd = cell_valid[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rv  = '0;
      assign rvd = 1'b0;
    end else begin : g_mid_r
      assign rv  = cell_value[g+1];
      assign rvd = cell_valid[g+1];
    end
    sst_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .key         (in_item.item_value),
      .desc        (desc_r),
      .ctl         (cell_ctl[g]),
      .left_value  (lv),
      .left_valid  (lvd),
      .right_value (rv),
      .right_valid (rvd),
      .value       (cell_value[g]),
      .valid       (cell_valid[g]),
      .flags       (cell_flags[g])
    );
  end

  // gather cell flags; the insert place is the first cell the key goes
  // before, or the first empty cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = cell_flags[i].match;
      place_vec[i] = cell_flags[i].ahead || !cell_valid[i];
      read_sel[i]  = cell_valid[i] && (32'(in_item.position) == 32'(i));
    end
  end

  assign found   = |match_vec;
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign ins_pre = prefix_or(place_vec);
  assign rem_pre = prefix_or(match_vec);
  assign ins_ok  = in_acc && (in_item.action == ACT_INSERT) && !found && !full;
  assign rem_ok  = in_acc && (in_item.action == ACT_REMOVE) && found;

  // per-cell shift control
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i].load_new   = ins_ok && ins_pre[i] &&
                               ((i == 0) || !ins_pre[(i+CAPACITY-1)%CAPACITY]);
      cell_ctl[i].load_left  = ins_ok && (i != 0) && ins_pre[(i+CAPACITY-1)%CAPACITY];
      cell_ctl[i].load_right = rem_ok && rem_pre[i];
    end
  end

  // read port: or of the one selected cell
  always_comb begin
    read_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_data = read_data | (read_sel[i] ? cell_value[i] : '0);
    end
  end
  assign read_hit = |read_sel;

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result for the accepted item
  always_comb begin
    out_item_nxt.status      = STS_DONE;
    out_item_nxt.entry_count = count_nxt;
    out_item_nxt.read_value  = '0;
    case (in_item.action)
      ACT_INSERT: begin
        if (found) begin
          out_item_nxt.status = STS_MISS;
        end else if (full) begin
          out_item_nxt.status = STS_FULL;
        end
      end
      ACT_REMOVE, ACT_QUERY: begin
        if (!found) begin
          out_item_nxt.status = STS_MISS;
        end
      end
      ACT_READ: begin
        if (read_hit) begin
          out_item_nxt.read_value = read_data;
        end else begin
          out_item_nxt.status = STS_BEYOND;
        end
      end
      default: begin
        out_item_nxt.status = STS_DONE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // valid bits track the count
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == 32'(count_r))
    else $error("valid bits disagree with entry count");

  // stored values are distinct
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("key matches more than one cell");

  // a successful insert grows the table by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  // count stays within the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

endmodule

@@ tb/sv/sorted_set_table_tb.sv @@
module sorted_set_table_tb;
  import sst_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 530;
  localparam int DIR_ROWS    = 26;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [1:0] {EP_FILL, EP_DRAIN, EP_MIX, EP_NOISE} episode_t;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one line of the directed stimulus; want is used only when typed is set
  typedef struct packed {
    row_kind_t kind;
    logic      order_bit;
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_stall;
  logic      out_valid;
  logic      cfg_ready;
  out_item_t out_item;

  // shadow of the table and the order register
  logic signed [VAL_W-1:0] tbl [CAPACITY];
  int        tbl_count = 0;
  logic      tbl_desc  = 1'b0;
  out_item_t expected_q [$];
  out_item_t oldest;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count     = 0;
  int n_items       = 0;
  int n_results     = 0;
  int n_full        = 0;
  int n_miss        = 0;
  int n_beyond      = 0;
  int n_cfg         = 0;
  int quiet         = 0;

  // directed stimulus: empty table, extremes, duplicates, then an order flip with entries held
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd0},  1'b1, '{STS_BEYOND, 7'd0, 32'sd0}},
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd63}, 1'b1, '{STS_BEYOND, 7'd0, 32'sd0}},
    '{ROW_ITEM, 1'b0, '{ACT_QUERY,  32'sd0, 6'd0},  1'b1, '{STS_MISS,   7'd0, 32'sd0}},
    '{ROW_ITEM, 1'b0, '{ACT_REMOVE, 32'sd5, 6'd0},  1'b1, '{STS_MISS,   7'd0, 32'sd0}},
    '{ROW_ITEM, 1'b0, '{ACT_INSERT, VAL_MAX, 6'd0}, 1'b1, '{STS_DONE,   7'd1, 32'sd0}},
    '{ROW_ITEM, 1'b0, '{ACT_INSERT, VAL_MIN, 6'd0}, 1'b1, '{STS_DONE,   7'd2, 32'sd0}},
    '{ROW_ITEM, 1'b0, '{ACT_INSERT, 32'sd0, 6'd0},  1'b1, '{STS_DONE,   7'd3, 32'sd0}},
    '{ROW_ITEM, 1'b0, '{ACT_INSERT, 32'sd0, 6'd0},  1'b1, '{STS_MISS,   7'd3, 32'sd0}},
    '{ROW_ITEM, 1'b0, '{ACT_INSERT, -32'sd1, 6'd0}, 1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd0},  1'b1, '{STS_DONE,   7'd4, VAL_MIN}},
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd3},  1'b1, '{STS_DONE,   7'd4, VAL_MAX}},
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd4},  1'b1, '{STS_BEYOND, 7'd4, 32'sd0}},
    '{ROW_ITEM, 1'b0, '{ACT_QUERY,  -32'sd1, 6'd0}, 1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_QUERY,  32'sd1, 6'd0},  1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_REMOVE, VAL_MIN, 6'd0}, 1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_REMOVE, 32'sd0, 6'd0},  1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd0},  1'b0, '0},
    '{ROW_CFG,  1'b1, '0,                           1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_INSERT, 32'sd5, 6'd0},  1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_INSERT, 32'sd100, 6'd0}, 1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd0},  1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd1},  1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd2},  1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_READ,   32'sd0, 6'd3},  1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_REMOVE, VAL_MAX, 6'd0}, 1'b0, '0},
    '{ROW_ITEM, 1'b0, '{ACT_QUERY,  32'sh5555_5555, 6'h2a}, 1'b0, '0}
  };

  sorted_set_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // strict order under the current setting
  function automatic logic precedes(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
    return tbl_desc ? (a > b) : (a < b);
  endfunction

  // applies one action to the shadow table and returns the result it gives
  function automatic out_item_t apply_action(in_item_t it);
    out_item_t r;
    int        hit;
    int        at;
    r   = '0;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl[i] == it.item_value) hit = i;
    end
    r.status = STS_DONE;
    case (it.action)
      ACT_INSERT: begin
        if (hit >= 0) begin
          r.status = STS_MISS;
        end else if (tbl_count >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          // first entry that the new value goes ahead of
          at = tbl_count;
          for (int i = tbl_count - 1; i >= 0; i--) begin
            if (precedes(it.item_value, tbl[i])) at = i;
          end
          for (int i = tbl_count; i > at; i--) tbl[i] = tbl[i-1];
          tbl[at] = it.item_value;
          tbl_count++;
        end
      end
      ACT_REMOVE: begin
        if (hit < 0) begin
          r.status = STS_MISS;
        end else begin
          for (int i = hit; i < tbl_count - 1; i++) tbl[i] = tbl[i+1];
          tbl_count--;
        end
      end
      ACT_QUERY: begin
        if (hit < 0) r.status = STS_MISS;
      end
      default: begin
        if (int'(it.position) < tbl_count) r.read_value = tbl[it.position];
        else r.status = STS_BEYOND;
      end
    endcase
    r.entry_count = CNT_W'(tbl_count);
    return r;
  endfunction

  // value source: stored entries, extremes, a narrow band round zero, or anything
  function automatic logic signed [VAL_W-1:0] pick_value(int pct_stored);
    int r;
    r = $urandom_range(99);
    if (tbl_count > 0 && r < pct_stored) return tbl[$urandom_range(tbl_count - 1)];
    r = $urandom_range(9);
    if (r == 0) return VAL_MIN;
    if (r == 1) return VAL_MAX;
    if (r < 5) return VAL_W'(int'($urandom_range(16)) - 8);
    return $urandom;
  endfunction

  function automatic in_item_t gen_item(episode_t ep);
    in_item_t it;
    int       r;
    it.item_value = $urandom;
    it.position   = POS_W'($urandom_range(63));
    it.action     = ACT_ACTION_RAND();
    r = $urandom_range(99);
    case (ep)
      EP_FILL: begin
        it.action = (r < 88) ? ACT_INSERT : ((r < 94) ? ACT_QUERY : ACT_READ);
        if ($urandom_range(99) < 8 && tbl_count > 0) it.item_value = tbl[$urandom_range(tbl_count - 1)];
      end
      EP_DRAIN: begin
        it.action     = (r < 85) ? ACT_REMOVE : ((r < 92) ? ACT_QUERY : ACT_READ);
        it.item_value = pick_value(85);
      end
      EP_MIX: it.item_value = pick_value(50);
      default: ;
    endcase
    // reads mostly land inside the stored range
    if (ep != EP_NOISE && it.action == ACT_READ && tbl_count > 0 && (r % 10) < 7)
      it.position = POS_W'($urandom_range(tbl_count - 1));
    return it;
  endfunction

  function automatic logic [ACT_W-1:0] ACT_ACTION_RAND();
    return ACT_W'($urandom_range(3));
  endfunction

  // present one item, hold it through stalls, record its expectation on acceptance
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = apply_action(it);
    expected_q.push_back(typed ? want : pred);
    n_items++;
    @(negedge clk);
  endtask

  // hold off the sender until every expected result is out, then let the pipe settle
  task automatic drain_wait();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_order(logic desc);
    drain_wait();
    cfg_valid <= 1'b1;
    cfg_data  <= desc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tbl_desc = desc;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one idling phase: fill first so the full table is reached, then random episodes
  task automatic run_phase(int s_pct, int r_pct, logic desc, logic mid_flip);
    episode_t ep;
    int       count;
    int       len;
    int       r;
    logic     mid_done;
    write_order(desc);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    count    = 0;
    mid_done = 1'b0;
    ep       = EP_FILL;
    while (count < PHASE_ITEMS) begin
      case (ep)
        EP_FILL:  len = (CAPACITY - tbl_count) * 3 / 2 + 12;
        EP_DRAIN: len = tbl_count * 3 / 2 + 6;
        EP_MIX:   len = 40;
        default:  len = 12;
      endcase
      repeat (len) begin
        send_item(gen_item(ep), 1'b0, '0);
        count++;
      end
      // halfway: either flip the order with entries held, or pause until idle
      if (!mid_done && count >= PHASE_ITEMS / 2) begin
        if (mid_flip) write_order(~desc);
        else drain_wait();
        mid_done = 1'b1;
      end
      r  = $urandom_range(9);
      ep = (r < 3) ? EP_FILL : ((r < 6) ? EP_DRAIN : ((r < 9) ? EP_MIX : EP_NOISE));
    end
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      err_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        err_count++;
        $error("result item with no item waiting: %0h", out_item);
      end else begin
        oldest = expected_q.pop_front();
        check_field("status", VAL_W'(oldest.status), VAL_W'(out_item.status));
        check_field("entry_count", VAL_W'(oldest.entry_count), VAL_W'(out_item.entry_count));
        check_field("read_value", oldest.read_value, out_item.read_value);
        n_results++;
        case (oldest.status)
          STS_MISS:   n_miss++;
          STS_FULL:   n_full++;
          STS_BEYOND: n_beyond++;
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed part under light sender idling and heavy receiver stalls
    send_idle_pct = 7;
    recv_idle_pct = 85;
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG)
        write_order(dir_table[i].order_bit);
      else
        send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
    end

    run_phase(7, 85, 1'b0, 1'b0);
    run_phase(85, 7, 1'b1, 1'b0);
    run_phase(0, 0, 1'b0, 1'b1);

    drain_wait();
    $display("covered %0d items, %0d results checked, %0d order register writes",
             n_items, n_results, n_cfg);
    $display("table-full rejects %0d, duplicate or absent %0d, reads past count %0d",
             n_full, n_miss, n_beyond);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sorted_set_table.sv
tb/sv/sorted_set_table_tb.sv
